// ===== rtl/adsr_envelope_level_unit_macros.svh =====
// Assertion macros shared by the envelope level unit RTL.
`ifndef ADSR_ENVELOPE_LEVEL_UNIT_MACROS_SVH
`define ADSR_ENVELOPE_LEVEL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ADSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ADSR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADSR_ASSERT(lbl, prop, msg)
`define ADSR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/adsr_pkg.sv =====
// Shared constants and register codes for the envelope level unit.
`default_nettype none
package adsr_pkg;

  localparam int TIME_BITS_DEF  = 24;
  localparam int LEVEL_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 3;

  localparam int PEAK_RESET    = 32768;
  localparam int ATTACK_RESET  = 4410;
  localparam int DECAY_RESET   = 4410;
  localparam int SUSTAIN_RESET = 6554;
  localparam int FADE_RESET    = 8820;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK    = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_DECAY   = 3'd2,
    REG_SUSTAIN = 3'd3,
    REG_FADE    = 3'd4
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/adsr_div_cell.sv =====
// One restoring-division cell: one quotient bit per transaction, passed to the next cell.
`default_nettype none
module adsr_div_cell #(
  parameter int W  = adsr_pkg::TIME_BITS_DEF,
  parameter int Q  = adsr_pkg::LEVEL_BITS_DEF,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [W-1:0]  up_rem,
  input  logic [Q-1:0]  up_acc,
  input  logic [W-1:0]  up_div,
  input  logic [SW-1:0] up_side,
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [W-1:0]  dn_rem,
  output logic [Q-1:0]  dn_acc,
  output logic [W-1:0]  dn_div,
  output logic [SW-1:0] dn_side
);

  logic          valid_r;
  logic [W-1:0]  rem_r;
  logic [Q-1:0]  acc_r;
  logic [W-1:0]  div_r;
  logic [SW-1:0] side_r;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_nxt;
  logic [Q-1:0]  acc_nxt;

  // Numerator bits leave the top of acc, quotient bits enter at the bottom.
  assign trial   = {up_rem, up_acc[Q-1]};
  assign diff    = trial - {1'b0, up_div};
  assign ge      = (trial >= {1'b0, up_div});
  assign rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
  assign acc_nxt = {up_acc[Q-2:0], ge};

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_r  <= rem_nxt;
      acc_r  <= acc_nxt;
      div_r  <= up_div;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_acc   = acc_r;
  assign dn_div   = div_r;
  assign dn_side  = side_r;

endmodule
`default_nettype wire

// ===== rtl/adsr_held_prep.sv =====
// Held-note piece selection and numerator build ahead of the first divider chain.
`default_nettype none
module adsr_held_prep #(
  parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
  parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [TIME_BITS-1:0]   elapsed,
  input  logic                   let_go,
  input  logic [TIME_BITS-1:0]   let_go_at,
  input  logic [LEVEL_BITS-1:0]  peak,
  input  logic [TIME_BITS-1:0]   attack,
  input  logic [TIME_BITS-1:0]   decay,
  input  logic [LEVEL_BITS-1:0]  sustain,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [TIME_BITS-1:0]   dn_rem,
  output logic [LEVEL_BITS-1:0]  dn_acc,
  output logic [TIME_BITS-1:0]   dn_div,
  output logic [2*TIME_BITS:0]   dn_side
);

  localparam int NUM_W = TIME_BITS + LEVEL_BITS;

  typedef enum logic [1:0] {
    SEG_ATTACK  = 2'd0,
    SEG_DECAY   = 2'd1,
    SEG_SUSTAIN = 2'd2
  } seg_t;

  // stage 1: pick the piece and form both products
  logic                  s1_valid_r;
  seg_t                  s1_seg_r;
  logic [NUM_W-1:0]      s1_m1_r;
  logic [NUM_W-1:0]      s1_m2_r;
  logic                  s1_up_r;
  logic [2*TIME_BITS:0]  s1_side_r;

  logic [TIME_BITS-1:0]  t_sel;
  logic [TIME_BITS:0]    ad_sum;
  logic                  is_att;
  logic                  is_dec;
  logic [TIME_BITS-1:0]  dt;
  logic                  up_nxt;
  logic [LEVEL_BITS-1:0] dpk;
  logic [TIME_BITS-1:0]  ma;
  seg_t                  seg_nxt;
  logic [NUM_W-1:0]      m1_nxt;
  logic [NUM_W-1:0]      m2_nxt;

  // stage 2: numerator split into remainder seed and low bits
  logic                  s2_valid_r;
  logic [TIME_BITS-1:0]  s2_rem_r;
  logic [LEVEL_BITS-1:0] s2_acc_r;
  logic [TIME_BITS-1:0]  s2_div_r;
  logic [2*TIME_BITS:0]  s2_side_r;

  logic [NUM_W:0]        sum;
  logic [NUM_W-1:0]      num_nxt;
  logic [TIME_BITS-1:0]  div_nxt;
  logic                  s1_ready;

  assign t_sel  = let_go ? let_go_at : elapsed;
  assign ad_sum = {1'b0, attack} + {1'b0, decay};
  assign is_att = (t_sel < attack);
  assign is_dec = ({1'b0, t_sel} < ad_sum);
  assign dt     = t_sel - attack;
  assign up_nxt = (sustain > peak);
  assign dpk    = up_nxt ? (sustain - peak) : (peak - sustain);
  assign ma     = is_att ? t_sel : decay;
  assign m1_nxt = NUM_W'(ma) * NUM_W'(peak);
  assign m2_nxt = NUM_W'(dt) * NUM_W'(dpk);

  always_comb begin
    if (is_att) begin
      seg_nxt = SEG_ATTACK;
    end else if (is_dec) begin
      seg_nxt = SEG_DECAY;
    end else begin
      seg_nxt = SEG_SUSTAIN;
    end
  end

  assign sum = {1'b0, s1_m1_r} + {1'b0, s1_m2_r};

  always_comb begin
    unique case (s1_seg_r)
      SEG_ATTACK: begin
        num_nxt = s1_m1_r;
        div_nxt = attack;
      end
      SEG_DECAY: begin
        // falling decay clamps at zero, rising decay adds
        if (s1_up_r) begin
          num_nxt = sum[NUM_W-1:0];
        end else if (s1_m1_r > s1_m2_r) begin
          num_nxt = s1_m1_r - s1_m2_r;
        end else begin
          num_nxt = '0;
        end
        div_nxt = decay;
      end
      SEG_SUSTAIN: begin
        num_nxt = NUM_W'(sustain);
        div_nxt = TIME_BITS'(1);
      end
      default: begin
        num_nxt = '0;
        div_nxt = TIME_BITS'(1);
      end
    endcase
  end

  assign s1_ready = !s2_valid_r || dn_ready;
  assign up_ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        s1_valid_r <= up_valid;
      end
      if (s1_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1_seg_r  <= seg_nxt;
      s1_m1_r   <= m1_nxt;
      s1_m2_r   <= m2_nxt;
      s1_up_r   <= up_nxt;
      s1_side_r <= {let_go, elapsed, let_go_at};
    end
    if (s1_ready && s1_valid_r) begin
      s2_rem_r  <= num_nxt[NUM_W-1:LEVEL_BITS];
      s2_acc_r  <= num_nxt[LEVEL_BITS-1:0];
      s2_div_r  <= div_nxt;
      s2_side_r <= s1_side_r;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_rem   = s2_rem_r;
  assign dn_acc   = s2_acc_r;
  assign dn_div   = s2_div_r;
  assign dn_side  = s2_side_r;

endmodule
`default_nettype wire

// ===== rtl/adsr_fade_prep.sv =====
// Release fade product and saturation check ahead of the second divider chain.
`default_nettype none
module adsr_fade_prep #(
  parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
  parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [LEVEL_BITS-1:0]  up_h,
  input  logic [2*TIME_BITS:0]   up_side,
  input  logic [TIME_BITS-1:0]   fade,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [TIME_BITS-1:0]   dn_rem,
  output logic [LEVEL_BITS-1:0]  dn_acc,
  output logic [TIME_BITS-1:0]   dn_div,
  output logic                   dn_sat
);

  localparam int PROD_W = LEVEL_BITS + TIME_BITS + 1;

  logic                  s1_valid_r;
  logic [PROD_W-1:0]     s1_n_r;
  logic                  s1_pos_r;
  logic                  s1_rel_r;
  logic [LEVEL_BITS-1:0] s1_h_r;
  logic [TIME_BITS-1:0]  s1_f_r;

  logic                  rel;
  logic [TIME_BITS-1:0]  t_cur;
  logic [TIME_BITS-1:0]  t_rel;
  logic [TIME_BITS-1:0]  f_eff;
  logic [TIME_BITS+1:0]  span;
  logic                  pos_nxt;
  logic [PROD_W-1:0]     n_nxt;

  logic                  s2_valid_r;
  logic [TIME_BITS-1:0]  s2_rem_r;
  logic [LEVEL_BITS-1:0] s2_acc_r;
  logic [TIME_BITS-1:0]  s2_div_r;
  logic                  s2_sat_r;

  logic [TIME_BITS:0]    hi;
  logic                  sat;
  logic [TIME_BITS-1:0]  rem_nxt;
  logic [LEVEL_BITS-1:0] acc_nxt;
  logic [TIME_BITS-1:0]  div_nxt;
  logic                  sat_nxt;
  logic                  s1_ready;

  assign rel   = up_side[2*TIME_BITS];
  assign t_cur = up_side[2*TIME_BITS-1:TIME_BITS];
  assign t_rel = up_side[TIME_BITS-1:0];
  assign f_eff = (fade == '0) ? TIME_BITS'(1) : fade;

  // span = release time + fade - elapsed, two's complement
  assign span    = {2'b00, t_rel} + {2'b00, f_eff} - {2'b00, t_cur};
  assign pos_nxt = !span[TIME_BITS+1] && (span != '0) && (up_h != '0);
  assign n_nxt   = PROD_W'(up_h) * PROD_W'(span[TIME_BITS:0]);

  assign hi  = s1_n_r[PROD_W-1:LEVEL_BITS];
  assign sat = (hi >= {1'b0, s1_f_r});

  // bypass cases run through the chain as a divide by one
  always_comb begin
    rem_nxt = '0;
    div_nxt = TIME_BITS'(1);
    sat_nxt = 1'b0;
    if (!s1_rel_r) begin
      acc_nxt = s1_h_r;
    end else if (!s1_pos_r) begin
      acc_nxt = '0;
    end else if (sat) begin
      acc_nxt = '1;
      sat_nxt = 1'b1;
    end else begin
      rem_nxt = hi[TIME_BITS-1:0];
      acc_nxt = s1_n_r[LEVEL_BITS-1:0];
      div_nxt = s1_f_r;
    end
  end

  assign s1_ready = !s2_valid_r || dn_ready;
  assign up_ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        s1_valid_r <= up_valid;
      end
      if (s1_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1_n_r   <= n_nxt;
      s1_pos_r <= pos_nxt;
      s1_rel_r <= rel;
      s1_h_r   <= up_h;
      s1_f_r   <= f_eff;
    end
    if (s1_ready && s1_valid_r) begin
      s2_rem_r <= rem_nxt;
      s2_acc_r <= acc_nxt;
      s2_div_r <= div_nxt;
      s2_sat_r <= sat_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_rem   = s2_rem_r;
  assign dn_acc   = s2_acc_r;
  assign dn_div   = s2_div_r;
  assign dn_sat   = s2_sat_r;

endmodule
`default_nettype wire

// ===== rtl/adsr_envelope_level_unit.sv =====
// Throughput: one transaction per cycle while out_stall is low; each divider is a chain of
// LEVEL_BITS cells, one quotient bit per cell, with stage-local stall so bubbles collapse.
// Reset (synchronous, rst_n low): all valid flags clear and the registers take their
// power-on values; the pipeline payload is not reset and no clearing pass runs.
`default_nettype none
`include "adsr_envelope_level_unit_macros.svh"
module adsr_envelope_level_unit #(
  parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
  parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF,
  localparam int CFG_W     = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [TIME_BITS-1:0]         in_elapsed,
  input  logic                         in_let_go,
  input  logic [TIME_BITS-1:0]         in_let_go_at,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [LEVEL_BITS-1:0]        out_level,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int SW1 = 2 * TIME_BITS + 1;

  logic [LEVEL_BITS-1:0] peak_r;
  logic [TIME_BITS-1:0]  attack_r;
  logic [TIME_BITS-1:0]  decay_r;
  logic [LEVEL_BITS-1:0] sustain_r;
  logic [TIME_BITS-1:0]  fade_r;

  logic                  held_ready;

  logic                  c1_valid [0:LEVEL_BITS];
  logic                  c1_ready [0:LEVEL_BITS];
  logic [TIME_BITS-1:0]  c1_rem   [0:LEVEL_BITS];
  logic [LEVEL_BITS-1:0] c1_acc   [0:LEVEL_BITS];
  logic [TIME_BITS-1:0]  c1_div   [0:LEVEL_BITS];
  logic [SW1-1:0]        c1_side  [0:LEVEL_BITS];

  logic                  c2_valid [0:LEVEL_BITS];
  logic                  c2_ready [0:LEVEL_BITS];
  logic [TIME_BITS-1:0]  c2_rem   [0:LEVEL_BITS];
  logic [LEVEL_BITS-1:0] c2_acc   [0:LEVEL_BITS];
  logic [TIME_BITS-1:0]  c2_div   [0:LEVEL_BITS];
  logic                  c2_sat   [0:LEVEL_BITS];

  // configuration registers; writes beyond the list drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r    <= LEVEL_BITS'(adsr_pkg::PEAK_RESET);
      attack_r  <= TIME_BITS'(adsr_pkg::ATTACK_RESET);
      decay_r   <= TIME_BITS'(adsr_pkg::DECAY_RESET);
      sustain_r <= LEVEL_BITS'(adsr_pkg::SUSTAIN_RESET);
      fade_r    <= TIME_BITS'(adsr_pkg::FADE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (adsr_pkg::cfg_reg_t'(cfg_index))
        adsr_pkg::REG_PEAK:    peak_r    <= cfg_data[LEVEL_BITS-1:0];
        adsr_pkg::REG_ATTACK:  attack_r  <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_DECAY:   decay_r   <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_SUSTAIN: sustain_r <= cfg_data[LEVEL_BITS-1:0];
        adsr_pkg::REG_FADE:    fade_r    <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  adsr_held_prep #(
    .TIME_BITS  (TIME_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_held_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (held_ready),
    .elapsed   (in_elapsed),
    .let_go    (in_let_go),
    .let_go_at (in_let_go_at),
    .peak      (peak_r),
    .attack    (attack_r),
    .decay     (decay_r),
    .sustain   (sustain_r),
    .dn_valid  (c1_valid[0]),
    .dn_ready  (c1_ready[0]),
    .dn_rem    (c1_rem[0]),
    .dn_acc    (c1_acc[0]),
    .dn_div    (c1_div[0]),
    .dn_side   (c1_side[0])
  );

  assign in_stall = !held_ready;

  for (genvar i = 0; i < LEVEL_BITS; i++) begin : g_chain_held
    adsr_div_cell #(
      .W  (TIME_BITS),
      .Q  (LEVEL_BITS),
      .SW (SW1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c1_valid[i]),
      .up_ready (c1_ready[i]),
      .up_rem   (c1_rem[i]),
      .up_acc   (c1_acc[i]),
      .up_div   (c1_div[i]),
      .up_side  (c1_side[i]),
      .dn_valid (c1_valid[i+1]),
      .dn_ready (c1_ready[i+1]),
      .dn_rem   (c1_rem[i+1]),
      .dn_acc   (c1_acc[i+1]),
      .dn_div   (c1_div[i+1]),
      .dn_side  (c1_side[i+1])
    );
  end

  adsr_fade_prep #(
    .TIME_BITS  (TIME_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_fade_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c1_valid[LEVEL_BITS]),
    .up_ready (c1_ready[LEVEL_BITS]),
    .up_h     (c1_acc[LEVEL_BITS]),
    .up_side  (c1_side[LEVEL_BITS]),
    .fade     (fade_r),
    .dn_valid (c2_valid[0]),
    .dn_ready (c2_ready[0]),
    .dn_rem   (c2_rem[0]),
    .dn_acc   (c2_acc[0]),
    .dn_div   (c2_div[0]),
    .dn_sat   (c2_sat[0])
  );

  for (genvar i = 0; i < LEVEL_BITS; i++) begin : g_chain_fade
    adsr_div_cell #(
      .W  (TIME_BITS),
      .Q  (LEVEL_BITS),
      .SW (1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c2_valid[i]),
      .up_ready (c2_ready[i]),
      .up_rem   (c2_rem[i]),
      .up_acc   (c2_acc[i]),
      .up_div   (c2_div[i]),
      .up_side  (c2_sat[i]),
      .dn_valid (c2_valid[i+1]),
      .dn_ready (c2_ready[i+1]),
      .dn_rem   (c2_rem[i+1]),
      .dn_acc   (c2_acc[i+1]),
      .dn_div   (c2_div[i+1]),
      .dn_side  (c2_sat[i+1])
    );
  end

  // last fade cell doubles as the output register
  assign c2_ready[LEVEL_BITS] = !out_stall;
  assign out_valid = c2_valid[LEVEL_BITS];
  assign out_level = c2_acc[LEVEL_BITS];

  `ADSR_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `ADSR_ASSERT(a_stall_only_backpressure, in_stall |-> (out_valid && out_stall), "input stall without output backpressure")
  `ADSR_ASSERT(a_held_rem_bound, c1_valid[LEVEL_BITS] |-> (c1_rem[LEVEL_BITS] < c1_div[LEVEL_BITS]), "held divider remainder not below divisor")
  `ADSR_ASSERT(a_fade_rem_bound, c2_valid[LEVEL_BITS] |-> (c2_rem[LEVEL_BITS] < c2_div[LEVEL_BITS]), "fade divider remainder not below divisor")
  `ADSR_ASSERT(a_sat_full_scale, (out_valid && c2_sat[LEVEL_BITS]) |-> (out_level == '1), "saturated result not full scale")

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the ADSR envelope level unit: scoreboard, drivers, random stimulus.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adsr_pkg::*;

  localparam int TW = TIME_BITS_DEF;
  localparam int LW = LEVEL_BITS_DEF;
  localparam int CW = (TW > LW) ? TW : LW;
  localparam longint TIME_MAX = (longint'(1) << TW) - 1;
  localparam longint LEVEL_MAX = (longint'(1) << LW) - 1;
  localparam int LATENCY = 2 * LW + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 114;
  localparam int MAX_PRINTS = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

  typedef struct {
    logic [TW-1:0] elapsed;
    logic          let_go;
    logic [TW-1:0] let_go_at;
    logic [LW-1:0] level;
  } level_due_t;

  class envelope_scoreboard;
    longint peak, attack, decay, sustain, fade;
    level_due_t due[$];
    int errors;

    function new();
      peak = PEAK_RESET;
      attack = ATTACK_RESET;
      decay = DECAY_RESET;
      sustain = SUSTAIN_RESET;
      fade = FADE_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
      case (idx)
        REG_PEAK:    peak = longint'(data) & LEVEL_MAX;
        REG_ATTACK:  attack = longint'(data) & TIME_MAX;
        REG_DECAY:   decay = longint'(data) & TIME_MAX;
        REG_SUSTAIN: sustain = longint'(data) & LEVEL_MAX;
        REG_FADE:    fade = longint'(data) & TIME_MAX;
        default: ;
      endcase
    endfunction

    // Level of the held note at tick t: attack ramp, decay line, then sustain.
    function longint held_piece(longint t);
      longint num, q;
      if (t < attack) return (t * peak) / attack;
      if (t < attack + decay) begin
        num = peak * decay - (t - attack) * (peak - sustain);
        if (num <= 0) return 0;
        q = num / decay;
        return (q > LEVEL_MAX) ? LEVEL_MAX : q;
      end
      return sustain;
    endfunction

    function logic [LW-1:0] level_of(logic [TW-1:0] e, logic lg, logic [TW-1:0] lga);
      longint h, f, num, q;
      if (!lg) return LW'(held_piece(longint'(e)));
      h = held_piece(longint'(lga));
      f = (fade == 0) ? 1 : fade;
      num = h * (longint'(lga) + f - longint'(e));
      if (num <= 0) return '0;
      q = num / f;
      if (q > LEVEL_MAX) q = LEVEL_MAX;
      return q[LW-1:0];
    endfunction

    function void note_input(logic [TW-1:0] e, logic lg, logic [TW-1:0] lga);
      level_due_t d;
      d.elapsed = e;
      d.let_go = lg;
      d.let_go_at = lga;
      d.level = level_of(e, lg, lga);
      due.insert(due.size(), d);
    endfunction

    function int pending();
      return due.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_level(logic [LW-1:0] got);
      level_due_t d;
      if (due.size() == 0) begin
        report($sformatf("level %0d with no transaction outstanding", got));
        return;
      end
      d = due.pop_front();
      if (got !== d.level)
        report($sformatf("elapsed=%0d let_go=%0b let_go_at=%0d: level %0d, want %0d",
                         d.elapsed, d.let_go, d.let_go_at, got, d.level));
    endtask

    task flush_leftovers();
      level_due_t d;
      while (due.size() != 0) begin
        d = due.pop_front();
        report($sformatf("no level for elapsed=%0d let_go=%0b let_go_at=%0d",
                         d.elapsed, d.let_go, d.let_go_at));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TW-1:0]        in_elapsed = '0;
  logic                 in_let_go = 1'b0;
  logic [TW-1:0]        in_let_go_at = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LW-1:0]        out_level;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]        cfg_data = '0;

  envelope_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  logic long_hold = 1'b0;
  int unsigned cycle_count = 0;

  adsr_envelope_level_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_elapsed  (in_elapsed),
    .in_let_go   (in_let_go),
    .in_let_go_at(in_let_go_at),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_level   (out_level),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_level(out_level);
    out_stall <= long_hold || ($urandom_range(99) < recv_idle);
  end

  function automatic longint clamp_time(longint v);
    if (v < 0) return 0;
    if (v > TIME_MAX) return TIME_MAX;
    return v;
  endfunction

  // Bias ticks toward the attack and decay boundaries of the current setting.
  function automatic longint pick_time();
    longint a, ad, v;
    a = sb.attack;
    ad = sb.attack + sb.decay;
    case ($urandom_range(4))
      0: v = longint'($urandom_range(TIME_MAX));
      1: v = longint'($urandom_range(clamp_time(a + 2)));
      2: v = a - 2 + longint'($urandom_range(4));
      3: v = ad - 4 + longint'($urandom_range(8));
      default: v = longint'($urandom_range(clamp_time(ad + 64)));
    endcase
    return clamp_time(v);
  endfunction

  function automatic longint pick_level();
    case ($urandom_range(3))
      0: return LEVEL_MAX;
      1: return longint'($urandom_range(32768));
      default: return longint'($urandom_range(LEVEL_MAX));
    endcase
  endfunction

  function automatic longint pick_span();
    case ($urandom_range(5))
      0: return 0;
      1: return longint'($urandom_range(64, 1));
      2, 3: return longint'($urandom_range(5000, 1));
      4: return longint'($urandom_range(TIME_MAX));
      default: return TIME_MAX;
    endcase
  endfunction

  task automatic set_idle(int s, int r);
    send_idle = s;
    recv_idle <= r;
  endtask

  task automatic send_item(longint e, bit lg, longint lga);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elapsed <= e[TW-1:0];
    in_let_go <= lg;
    in_let_go_at <= lga[TW-1:0];
    do @(posedge clk); while (in_stall);
    sb.note_input(e[TW-1:0], lg, lga[TW-1:0]);
  endtask

  task automatic send_random_item();
    longint e, r;
    bit lg;
    int k;
    k = $urandom_range(99);
    if (k < 45) begin
      e = pick_time();
      lg = 1'b0;
      r = longint'($urandom_range(TIME_MAX));
    end else if (k < 90) begin
      // Released note: place elapsed around the fade window of the release time.
      r = pick_time();
      lg = 1'b1;
      case ($urandom_range(3))
        0, 1: e = r + longint'($urandom_range(sb.fade));
        2: e = r - longint'($urandom_range(16));
        default: e = r + sb.fade - 2 + longint'($urandom_range(4));
      endcase
      e = clamp_time(e);
    end else begin
      e = longint'($urandom_range(TIME_MAX));
      lg = 1'($urandom_range(1));
      r = longint'($urandom_range(TIME_MAX));
    end
    send_item(e, lg, r);
  endtask

  // Keep valid high across consecutive writes; the caller drops it.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CW-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data[CW-1:0]);
  endtask

  task automatic program_regs(longint pk, longint at, longint dc, longint su, longint fd,
                              bit with_unused);
    cfg_write(REG_PEAK, pk);
    cfg_write(REG_ATTACK, at);
    cfg_write(REG_DECAY, dc);
    cfg_write(REG_SUSTAIN, su);
    cfg_write(REG_FADE, fd);
    if (with_unused) cfg_write(REG_UNUSED, longint'($urandom_range(TIME_MAX)));
    cfg_valid <= 1'b0;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    longint fd;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(12, 56);

    // Power-on setting: walk the attack, decay and sustain pieces, then release cases.
    send_item(0, 0, 0);
    send_item(2205, 0, 0);
    send_item(4409, 0, 0);
    send_item(4410, 0, 0);
    send_item(6615, 0, 0);
    send_item(8819, 0, 0);
    send_item(8820, 0, 0);
    send_item(TIME_MAX, 0, TIME_MAX);
    send_item(2000 + 4410, 1, 2000);
    send_item(0, 1, TIME_MAX);
    send_item(3000 + 8820 + 5, 1, 3000);
    send_item(0, 1, 0);
    send_item(TIME_MAX, 1, TIME_MAX);
    finish_phase();

    // No attack, no decay, zero fade, and a write to an unmapped index.
    program_regs(40000, 0, 0, 20000, 0, 1);
    send_item(0, 0, 0);
    send_item(5, 1, 5);
    send_item(6, 1, 5);
    finish_phase();

    // Sustain above peak: the decay line rises.
    program_regs(1000, 100, 200, 60000, 50, 0);
    send_item(200, 0, 0);
    send_item(299, 0, 0);
    send_item(175, 1, 150);
    finish_phase();

    program_regs(LEVEL_MAX, TIME_MAX, TIME_MAX, LEVEL_MAX, TIME_MAX, 0);
    send_item(TIME_MAX, 0, 0);
    send_item(TIME_MAX - 1, 0, 0);
    send_item(0, 1, TIME_MAX - 1);
    finish_phase();

    program_regs(0, 1, 1, 0, 1, 0);
    send_item(0, 0, 0);
    send_item(1, 0, 0);
    send_item(0, 1, 1);
    finish_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 3) set_idle(12, 56);
      else if (p < 6) set_idle(56, 12);
      else set_idle(0, 0);
      fd = pick_span();
      if (fd == 0) fd = 1;
      program_regs(pick_level(), pick_span(), pick_span(), pick_level(), fd, p == 4);
      if (p == RANDOM_PHASES - 1) begin
        // Hold the result side off long enough for the pipeline to back up.
        fork
          begin
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
          end
        join_none
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
      finish_phase();
    end

    repeat (LATENCY + 4) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/adsr_pkg.sv
rtl/adsr_div_cell.sv
rtl/adsr_held_prep.sv
rtl/adsr_fade_prep.sv
rtl/adsr_envelope_level_unit.sv
dv/tb.sv
